// ----- sv/vfd_text_punctuation_merge_defines.svh -----
// assertion helpers shared by the display encoder
`ifndef VFD_TEXT_PUNCTUATION_MERGE_DEFINES_SVH
`define VFD_TEXT_PUNCTUATION_MERGE_DEFINES_SVH

// property must hold at every edge out of reset
`define VTPM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define VTPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vtpm_pkg.sv -----
package vtpm_pkg;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_TILDE     = 8'h7E;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_PERIOD    = 8'h2E;
    localparam logic [7:0] CHAR_QMARK     = 8'h3F;
    localparam logic [7:0] CHAR_AT        = 8'h40;
    localparam logic [7:0] CHAR_USCORE    = 8'h5F;

    localparam logic [7:0] CASE_OFFSET    = 8'h20;
    localparam logic [7:0] COMMA_LOW_ADD  = 8'h60;
    localparam logic [7:0] COMMA_HIGH_ADD = 8'hA0;
    localparam logic [7:0] PERIOD_ADD     = 8'h80;

    localparam logic [1:0] QUEUE_DEPTH    = 2'd2;
    localparam logic [1:0] COUNT_SAT      = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
    } result_t;

    // up to two results handed together from the encoder to the output queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] upcase(input logic [7:0] raw);
        logic [7:0] c;
        c = raw;
        if (raw inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            c = raw - CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic is_printable(input logic [7:0] c);
        return (c inside {[CHAR_SPACE:CHAR_BACKTICK], [CHAR_LBRACE:CHAR_TILDE]});
    endfunction

    function automatic logic is_bare_punct(input logic [7:0] v);
        return (v inside {CHAR_COMMA, CHAR_PERIOD});
    endfunction

    function automatic logic [7:0] merge_punct(input logic [7:0] held, input logic [7:0] nxt);
        logic [7:0] v;
        v = held;
        if (nxt == CHAR_COMMA) begin
            if (held inside {[CHAR_SPACE:CHAR_QMARK]}) begin
                v = held + COMMA_LOW_ADD;
            end else if (held inside {[CHAR_AT:CHAR_USCORE]}) begin
                v = held + COMMA_HIGH_ADD;
            end
        end else if (nxt == CHAR_PERIOD) begin
            if (held inside {[CHAR_SPACE:CHAR_USCORE]}) begin
                v = held + PERIOD_ADD;
            end
        end
        return v;
    endfunction

endpackage

// ----- sv/vfd_text_punctuation_merge.sv -----
// vfd display text encoder
// input channel s_*: one raw character per item, s_last_char marks the end of a
//   string. lowercase is folded to uppercase, non-printing characters dropped.
// output channel m_*: display code items; a comma or period after a character in
//   0x20-0x5F merges into it, and the item caused by the last character has
//   m_end_of_string set (a bare marker with m_byte_valid low if no code is left).
// path: an accepted item is captured in the input register; its results pass the
//   encoder logic and are registered in the output queue before they are presented.
// throughput: one item per cycle while m_ready stays high and each item gives at
//   most one result; an item that gives two results waits in the input register
//   until the two-entry output queue is empty, as its single result port drains it.
// stalls: while m_ready is low, results collect in the output queue and the
//   input register, then s_ready drops; nothing is lost or repeated.
// reset: aresetn (synchronous, active low) empties the input register and the
//   queue and clears the held character and count; s_ready is high right after.
module vfd_text_punctuation_merge (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_string
);
    import vtpm_pkg::*;

    push_t      push;
    logic [1:0] free_slots;
    result_t    head;

    vtpm_encoder u_encoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .free_slots  (free_slots),
        .push        (push)
    );

    vtpm_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .free_slots (free_slots),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_out_byte      = head.out_byte;
    assign m_byte_valid    = head.byte_valid;
    assign m_end_of_string = head.end_of_string;

endmodule

// ----- sv/vtpm_encoder.sv -----
module vtpm_encoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_char_code,
    input  logic             s_last_char,
    input  logic [1:0]       free_slots,
    output vtpm_pkg::push_t  push
);
    import vtpm_pkg::*;

    logic       item_valid_reg, item_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic [6:0] held_reg, held_next;
    logic [1:0] acc_count_reg, acc_count_next;

    logic       fire;
    logic [7:0] c;
    logic       acc;
    logic [7:0] pair_byte;
    logic       pair_emit;
    logic [6:0] held_upd;
    logic [1:0] count_upd;
    logic       final_emit;
    logic [1:0] need;
    result_t    pair_res, final_res;

    always_comb begin
        c         = upcase(char_reg);
        acc       = is_printable(c);
        pair_byte = merge_punct({1'b0, held_reg}, c);
        pair_emit = acc && (acc_count_reg != 2'd0) && !is_bare_punct(pair_byte);
        held_upd  = acc ? c[6:0] : held_reg;
        if (!acc) begin
            count_upd = acc_count_reg;
        end else if (acc_count_reg == COUNT_SAT) begin
            count_upd = COUNT_SAT;
        end else begin
            count_upd = acc_count_reg + 2'd1;
        end
        // closing byte goes out only for two or more accepted characters
        final_emit = (count_upd == COUNT_SAT) && !is_bare_punct({1'b0, held_upd});

        pair_res.out_byte      = pair_byte;
        pair_res.byte_valid    = 1'b1;
        pair_res.end_of_string = 1'b0;
        if (final_emit) begin
            final_res.out_byte   = {1'b0, held_upd};
            final_res.byte_valid = 1'b1;
        end else begin
            final_res.out_byte   = 8'h00;
            final_res.byte_valid = 1'b0;
        end
        final_res.end_of_string = 1'b1;

        need = {1'b0, pair_emit} + {1'b0, last_reg};
        fire = item_valid_reg && (need <= free_slots);

        push.count  = fire ? need : 2'd0;
        push.first  = pair_emit ? pair_res : final_res;
        push.second = final_res;

        s_ready = !item_valid_reg || fire;

        if (s_valid && s_ready) begin
            item_valid_next = 1'b1;
        end else if (fire) begin
            item_valid_next = 1'b0;
        end else begin
            item_valid_next = item_valid_reg;
        end

        held_next      = held_reg;
        acc_count_next = acc_count_reg;
        if (fire) begin
            if (last_reg) begin
                held_next      = '0;
                acc_count_next = '0;
            end else begin
                held_next      = held_upd;
                acc_count_next = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            held_reg       <= '0;
            acc_count_reg  <= '0;
        end else begin
            item_valid_reg <= item_valid_next;
            held_reg       <= held_next;
            acc_count_reg  <= acc_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
            last_reg <= s_last_char;
        end
    end

endmodule

// ----- sv/vtpm_out_queue.sv -----
`include "vfd_text_punctuation_merge_defines.svh"

module vtpm_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  vtpm_pkg::push_t   push,
    output logic [1:0]        free_slots,
    output logic              m_valid,
    input  logic              m_ready,
    output vtpm_pkg::result_t head
);
    import vtpm_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] fill_reg, fill_next;
    logic       pop;
    logic [1:0] remain;

    always_comb begin
        m_valid    = (fill_reg != 2'd0);
        head       = slot0_reg;
        free_slots = QUEUE_DEPTH - fill_reg;
        pop        = m_valid && m_ready;
        remain     = fill_reg - {1'b0, pop};

        // shift down on pop, then append new items behind what remains
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (remain == 2'd0) begin
            if (push.count != 2'd0) begin
                slot0_next = push.first;
            end
            if (push.count == 2'd2) begin
                slot1_next = push.second;
            end
        end else if (remain == 2'd1) begin
            if (push.count != 2'd0) begin
                slot1_next = push.first;
            end
        end
        fill_next = remain + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `VTPM_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= QUEUE_DEPTH, "queue fill beyond depth")
    `VTPM_ASSERT_IMP(a_no_overflow, aclk, aresetn, push.count != 2'd0,
        ({1'b0, fill_reg} + {1'b0, push.count}) <= 3'd2, "push overflows queue")
    `VTPM_ASSERT_NEXT(a_drain_empty, aclk, aresetn,
        pop && (fill_reg == 2'd1) && (push.count == 2'd0), !m_valid, "queue not empty after drain")

endmodule
